[rtl/nec_tx_pkg.sv]
// Shared types and constants for the NEC infrared transmitter.
package nec_tx_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_REPEAT = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Transmission phases
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_LEAD_BURST  = 3'd1,
    PH_LEAD_SPACE  = 3'd2,
    PH_BIT_BURST   = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_FINAL_BURST = 3'd5
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CARRIER_HALF = 2'd0,
    REG_UNIT_CYCLES  = 2'd1,
    REG_EXTENDED     = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  localparam int HalfW  = 10;
  localparam int UnitW  = 8;
  localparam int UnitsW = 5;
  localparam int BitsW  = 6;
  localparam int FrameW = 32;

  // Segment lengths in protocol units
  localparam logic [UnitsW-1:0] LeadBurstUnits    = 5'd16;
  localparam logic [UnitsW-1:0] LeadSpaceUnits    = 5'd8;
  localparam logic [UnitsW-1:0] RepeatSpaceUnits  = 5'd4;
  localparam logic [UnitsW-1:0] OneSpaceUnits     = 5'd3;
  localparam logic [UnitsW-1:0] ShortUnits        = 5'd1;
  localparam logic [BitsW-1:0]  FrameBits         = 6'd32;

  // Reset values of the timing registers
  localparam logic [HalfW-1:0] HalfReset = 10'd13;
  localparam logic [UnitW-1:0] UnitReset = 8'd21;

endpackage

[rtl/nec_ir_transmitter.sv]
// NEC infrared transmitter: frame and repeat sequencer with carrier modulation.
//
// Every request on the input stream yields exactly one result, at a sustained
// rate of one request per clock unless a result waits on a stalled output: the
// whole step (carrier count, unit count, segment change or frame load) is one
// registered pass from the state registers into the result register, and a
// waiting result does not block the next request while the result register is
// being emptied in the same cycle. A timebase tick advances the carrier counters;
// a start request loads a frame or repeat when idle and is ignored when busy.
// tx_level is bit 0 of m_tdata, busy_res bit 1, and frame_done travels as
// m_tlast.
module nec_ir_transmitter
  import nec_tx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wr_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // addr_field [15:0], command_field [31:16]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // tx_level [0], busy_res [1], zero [7:2]
  output logic        m_tlast    // frame_done
);

  // configuration registers
  logic [HalfW-1:0] carrier_half_period;
  logic [UnitW-1:0] unit_cycles;
  logic             extended_mode;

  // sequencer state
  phase_t            phase, phase_next;
  logic [FrameW-1:0] frame_shift, frame_shift_next;
  logic [BitsW-1:0]  bits_left, bits_left_next;
  logic [UnitsW-1:0] units_left, units_left_next;
  logic [UnitW-1:0]  carrier_cycles_left, carrier_cycles_left_next;
  logic [HalfW-1:0]  half_period_ticks, half_period_ticks_next;
  logic              carrier_phase, carrier_phase_next;
  logic              repeat_active, repeat_active_next;

  // result register
  logic       out_valid;
  logic       out_level, out_busy, out_done;
  logic       res_level, res_busy, res_done;

  logic             accept;
  cmd_t             cmd;
  logic [15:0]      addr_in, comm_in;
  logic [HalfW-1:0] hp, hpt_inc;
  logic [UnitW-1:0] unit_len;
  logic             busy_now;

  assign cmd     = cmd_t'(s_tuser);
  assign addr_in = s_tdata[15:0];
  assign comm_in = s_tdata[31:16];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign hp       = (carrier_half_period == '0) ? HalfW'(1) : carrier_half_period;
  assign unit_len = (unit_cycles == '0) ? UnitW'(1) : unit_cycles;
  assign hpt_inc  = half_period_ticks + HalfW'(1);
  assign busy_now = (phase != PH_IDLE);

  // take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_half_period <= HalfReset;
      unit_cycles         <= UnitReset;
      extended_mode       <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CARRIER_HALF: carrier_half_period <= cfg_wr_data;
        REG_UNIT_CYCLES:  unit_cycles         <= cfg_wr_data[UnitW-1:0];
        REG_EXTENDED:     extended_mode       <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // work out the next sequencer state and the result of one request
  always_comb begin
    logic seg_end;
    phase_next               = phase;
    frame_shift_next         = frame_shift;
    bits_left_next           = bits_left;
    units_left_next          = units_left;
    carrier_cycles_left_next = carrier_cycles_left;
    half_period_ticks_next   = half_period_ticks;
    carrier_phase_next       = carrier_phase;
    repeat_active_next       = repeat_active;
    res_done                 = 1'b0;
    seg_end                  = 1'b0;

    if (cmd == CMD_TICK) begin
      if (busy_now) begin
        // advance the carrier half period, then the carrier cycle, then the unit
        if (hpt_inc < hp && hpt_inc != '0) begin
          half_period_ticks_next = hpt_inc;
        end else begin
          half_period_ticks_next = '0;
          if (!carrier_phase) begin
            carrier_phase_next = 1'b1;
          end else begin
            carrier_phase_next = 1'b0;
            if (carrier_cycles_left > UnitW'(1)) begin
              carrier_cycles_left_next = carrier_cycles_left - UnitW'(1);
            end else begin
              carrier_cycles_left_next = unit_len;
              if (units_left > UnitsW'(1)) begin
                units_left_next = units_left - UnitsW'(1);
              end else begin
                seg_end = 1'b1;
              end
            end
          end
        end
      end
      // move to the next segment
      if (seg_end) begin
        carrier_cycles_left_next = unit_len;
        half_period_ticks_next   = '0;
        carrier_phase_next       = 1'b0;
        case (phase)
          PH_LEAD_BURST: begin
            phase_next      = PH_LEAD_SPACE;
            units_left_next = repeat_active ? RepeatSpaceUnits : LeadSpaceUnits;
          end
          PH_LEAD_SPACE: begin
            units_left_next = ShortUnits;
            if (repeat_active) begin
              phase_next = PH_FINAL_BURST;
            end else begin
              phase_next     = PH_BIT_BURST;
              bits_left_next = FrameBits;
            end
          end
          PH_BIT_BURST: begin
            phase_next      = PH_BIT_SPACE;
            units_left_next = frame_shift[0] ? OneSpaceUnits : ShortUnits;
          end
          PH_BIT_SPACE: begin
            frame_shift_next = frame_shift >> 1;
            bits_left_next   = bits_left - BitsW'(1);
            units_left_next  = ShortUnits;
            phase_next       = (bits_left_next == '0) ? PH_FINAL_BURST : PH_BIT_BURST;
          end
          default: begin
            phase_next         = PH_IDLE;
            units_left_next    = '0;
            repeat_active_next = 1'b0;
            res_done           = 1'b1;
          end
        endcase
      end
    end else if (!busy_now && (cmd == CMD_FRAME || cmd == CMD_REPEAT)) begin
      // load a frame or repeat code
      if (cmd == CMD_FRAME) begin
        if (extended_mode) begin
          frame_shift_next = {comm_in, addr_in};
        end else begin
          frame_shift_next = {~comm_in[7:0], comm_in[7:0], ~addr_in[7:0], addr_in[7:0]};
        end
        repeat_active_next = 1'b0;
      end else begin
        repeat_active_next = 1'b1;
      end
      bits_left_next           = '0;
      phase_next               = PH_LEAD_BURST;
      units_left_next          = LeadBurstUnits;
      carrier_cycles_left_next = unit_len;
      half_period_ticks_next   = '0;
      carrier_phase_next       = 1'b0;
    end

    // a tick reports the level before advancing, a start the level after loading
    if (cmd == CMD_TICK) begin
      res_busy  = busy_now;
      res_level = (phase == PH_LEAD_BURST || phase == PH_BIT_BURST ||
                   phase == PH_FINAL_BURST) && !carrier_phase;
    end else begin
      res_busy  = (phase_next != PH_IDLE);
      res_level = (phase_next == PH_LEAD_BURST || phase_next == PH_BIT_BURST ||
                   phase_next == PH_FINAL_BURST) && !carrier_phase_next;
    end
  end

  // hold the sequencer state, advance it on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      frame_shift         <= '0;
      bits_left           <= '0;
      units_left          <= '0;
      carrier_cycles_left <= '0;
      half_period_ticks   <= '0;
      carrier_phase       <= 1'b0;
      repeat_active       <= 1'b0;
    end else if (accept) begin
      phase               <= phase_next;
      frame_shift         <= frame_shift_next;
      bits_left           <= bits_left_next;
      units_left          <= units_left_next;
      carrier_cycles_left <= carrier_cycles_left_next;
      half_period_ticks   <= half_period_ticks_next;
      carrier_phase       <= carrier_phase_next;
      repeat_active       <= repeat_active_next;
    end
  end

  // result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level <= res_level;
      out_busy  <= res_busy;
      out_done  <= res_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_busy, out_level};
  assign m_tlast  = out_done;

  // the emitter is only driven during a transmission
  a_level_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> !m_tdata[0])
    else $error("tx_level high while not busy");

  // an end of transmission is reported on a busy tick
  a_done_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1])
    else $error("frame_done without busy");

  // idle leaves the carrier phase low and the unit count cleared
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !carrier_phase && units_left == '0)
    else $error("idle with live counters");

  // the bit count never exceeds one frame
  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    bits_left <= FrameBits)
    else $error("bit count out of range");

endmodule
